### design/cca_pkg.sv
// Package for the cluster chain allocator: widths, command and status codes.
// No dependencies.
package cca_pkg;
   localparam int NumClusters = 4096;
   localparam int CluW = 12;
   localparam int CfgW = 13;
   localparam logic [CluW-1:0] FreeMax = 12'hFFF;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_WALK  = 2'd2;
   localparam logic [1:0] CMD_LINK  = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOSPC  = 2'd1;
   localparam logic [1:0] ST_RANGE  = 2'd2;
   localparam logic [1:0] ST_BROKEN = 2'd3;

   typedef logic [CluW-1:0] clu_type;
endpackage

### design/cluster_chain_allocator_top.sv
// Cluster chain allocator top level: used-bit and link memories, command sequencer.
// Depends on cca_pkg.
//
//  port group | dir | handshake       | contents
//  req_*      | in  | req_valid/ready | cmd, cluster_no, amount, link_target
//  rsp_*      | out | rsp_valid/ready | status, result_cluster, free_left
//  csr_*      | in  | csr_wr_en       | clusters_in_use
//
// One request at a time. Each table step is a memory read, then a modify/write;
// allocate, free and walk make one step per cluster visited, and allocate undo
// makes one more per cluster taken. Link, a zero-count allocate and a free of an
// out-of-range cluster finish in the accepting cycle. After reset a clearing pass
// over all 4096 clusters runs before the first request. The result sits in an
// output register; a new request is taken while it waits, not while a result is pending.
module cluster_chain_allocator_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_cmd,
   input  cca_pkg::clu_type     req_cluster_no,
   input  cca_pkg::clu_type     req_amount,
   input  cca_pkg::clu_type     req_link_target,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output cca_pkg::clu_type     rsp_result_cluster,
   output cca_pkg::clu_type     rsp_free_left,
   input  logic                 csr_wr_en,
   input  logic [cca_pkg::CfgW-1:0] csr_clusters_in_use
);
   import cca_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_AREAD = 4'd2, S_ACHK = 4'd3,
                          S_UREAD = 4'd4, S_UNEXT = 4'd5, S_FREAD = 4'd6, S_FNEXT = 4'd7,
                          S_WREAD = 4'd8, S_WNEXT = 4'd9, S_DONE = 4'd10;

   logic            used_mem [NumClusters];
   clu_type         link_mem [NumClusters];
   logic            used_rd;
   clu_type         link_rd;
   logic            used_we, used_wd, link_we;
   clu_type         used_wa, link_wa, link_wd, rd_addr;

   logic [3:0]      state_ff, state_in;
   logic [CfgW-1:0] span_ff, span_in;
   clu_type         free_ff, free_in, saved_ff, saved_in;
   clu_type         pos_ff, pos_in, first_ff, first_in, prev_ff, prev_in;
   clu_type         got_ff, got_in, amt_ff, amt_in, cnt_ff, cnt_in;
   logic [CfgW-1:0] steps_ff, steps_in;
   logic            pend_ff, pend_in;
   logic [1:0]      st_ff, st_in;
   clu_type         res_ff, res_in;
   logic            ov_ff, ov_in;
   logic [1:0]      ost_ff, ost_in;
   clu_type         ores_ff, ores_in, ofree_ff, ofree_in;

   logic [CfgW-1:0] span_w;
   logic            fin, take;
   clu_type         nxt;

   always_comb begin
      priority if (csr_clusters_in_use < CfgW'(2)) span_w = CfgW'(2);
      else if (csr_clusters_in_use > CfgW'(NumClusters)) span_w = CfgW'(NumClusters);
      else span_w = csr_clusters_in_use;
   end

   always_ff @(posedge clock) begin
      if (used_we) used_mem[used_wa] <= used_wd;
      if (link_we) link_mem[link_wa] <= link_wd;
      used_rd <= used_mem[rd_addr];
      link_rd <= link_mem[rd_addr];
   end

   assign req_ready = (state_ff == S_IDLE) && !pend_ff;
   assign take = req_valid && req_ready;
   assign rsp_valid = ov_ff;
   assign rsp_status = ost_ff;
   assign rsp_result_cluster = ores_ff;
   assign rsp_free_left = ofree_ff;

   always_comb begin
      state_in = state_ff; span_in = span_ff; free_in = free_ff; saved_in = saved_ff;
      pos_in = pos_ff; first_in = first_ff; prev_in = prev_ff; got_in = got_ff;
      amt_in = amt_ff; cnt_in = cnt_ff; steps_in = steps_ff; pend_in = pend_ff;
      st_in = st_ff; res_in = res_ff; ov_in = ov_ff; ost_in = ost_ff;
      ores_in = ores_ff; ofree_in = ofree_ff;
      used_we = 1'b0; used_wd = 1'b0; used_wa = pos_ff;
      link_we = 1'b0; link_wd = '0; link_wa = pos_ff; rd_addr = pos_ff;
      fin = 1'b0; nxt = '0;

      if (ov_ff && rsp_ready) ov_in = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            used_we = 1'b1; used_wd = (pos_ff == '0);
            link_we = 1'b1;
            pos_in = pos_ff + 1'b1;
            if (pos_ff == FreeMax) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (pend_ff && !ov_in) begin
               ov_in = 1'b1; ost_in = st_ff; ores_in = res_ff; ofree_in = free_ff;
               pend_in = 1'b0;
            end else if (take) begin
               st_in = ST_OK; res_in = '0; amt_in = req_amount;
               unique case (req_cmd)
                  CMD_ALLOC: begin
                     if (req_amount == '0) fin = 1'b1;
                     else begin
                        saved_in = free_ff; pos_in = clu_type'(1); got_in = '0;
                        state_in = S_AREAD;
                     end
                  end
                  CMD_FREE: begin
                     if ({1'b0, req_cluster_no} >= span_ff) begin
                        st_in = ST_RANGE; fin = 1'b1;
                     end else begin
                        pos_in = req_cluster_no; steps_in = '0; state_in = S_FREAD;
                     end
                  end
                  CMD_WALK: begin
                     pos_in = req_cluster_no; cnt_in = '0; state_in = S_WREAD;
                  end
                  default: begin
                     if ({1'b0, req_cluster_no} >= span_ff) st_in = ST_RANGE;
                     else begin
                        link_we = 1'b1; link_wa = req_cluster_no; link_wd = req_link_target;
                     end
                     fin = 1'b1;
                  end
               endcase
            end
         end
         S_AREAD: begin
            if ({1'b0, pos_ff} >= span_ff) begin
               pos_in = first_ff; cnt_in = '0; free_in = saved_ff; st_in = ST_NOSPC;
               state_in = (got_ff == '0) ? S_IDLE : S_UREAD;
               fin = (got_ff == '0);
            end else state_in = S_ACHK;
         end
         S_ACHK: begin
            state_in = S_AREAD;
            if (!used_rd) begin
               used_we = 1'b1; used_wd = 1'b1;
               if (free_ff != '0) free_in = free_ff - 1'b1;
               if (got_ff == '0) first_in = pos_ff;
               else begin
                  link_we = 1'b1; link_wa = prev_ff; link_wd = pos_ff;
               end
               prev_in = pos_ff; got_in = got_ff + 1'b1;
               if (got_ff + 1'b1 == amt_ff) begin
                  state_in = S_DONE;
                  res_in = (got_ff == '0) ? pos_ff : first_ff;
               end
            end
            pos_in = pos_ff + 1'b1;
            if (pos_ff == FreeMax && state_in != S_DONE) begin
               pos_in = (got_ff == '0 && !used_rd) ? pos_ff : first_ff;
               cnt_in = '0; st_in = ST_NOSPC;
               if (got_ff == '0 && used_rd) begin
                  free_in = saved_ff; fin = 1'b1; state_in = S_IDLE;
               end else state_in = S_UREAD;
            end
         end
         S_DONE: begin
            link_we = 1'b1; link_wa = prev_ff; link_wd = '0; fin = 1'b1;
            state_in = S_IDLE;
         end
         S_UREAD: state_in = S_UNEXT;
         S_UNEXT: begin
            used_we = 1'b1; used_wd = 1'b0;
            cnt_in = cnt_ff + 1'b1; pos_in = link_rd;
            if (cnt_ff + 1'b1 == got_ff) begin
               free_in = saved_ff; fin = 1'b1; state_in = S_IDLE;
            end else state_in = S_UREAD;
         end
         S_FREAD: state_in = S_FNEXT;
         S_FNEXT: begin
            used_we = 1'b1; used_wd = 1'b0;
            if (free_ff != FreeMax) free_in = free_ff + 1'b1;
            steps_in = steps_ff + 1'b1; nxt = link_rd;
            pos_in = nxt; state_in = S_FREAD;
            priority if (nxt == '0) begin fin = 1'b1; state_in = S_IDLE; end
            else if ({1'b0, nxt} >= span_ff) begin
               st_in = ST_RANGE; fin = 1'b1; state_in = S_IDLE;
            end else if (steps_ff + 1'b1 >= span_ff) begin
               st_in = ST_BROKEN; fin = 1'b1; state_in = S_IDLE;
            end
         end
         S_WREAD: begin
            if (pos_ff == '0) begin st_in = ST_BROKEN; fin = 1'b1; state_in = S_IDLE; end
            else if ({1'b0, pos_ff} >= span_ff) begin
               st_in = ST_RANGE; fin = 1'b1; state_in = S_IDLE;
            end else if (cnt_ff == amt_ff) begin
               res_in = pos_ff; fin = 1'b1; state_in = S_IDLE;
            end else state_in = S_WNEXT;
         end
         S_WNEXT: begin
            pos_in = link_rd; cnt_in = cnt_ff + 1'b1; state_in = S_WREAD;
         end
         default: state_in = S_IDLE;
      endcase

      if (fin) begin
         state_in = S_IDLE;
         if (!ov_in) begin
            ov_in = 1'b1; ost_in = st_in; ores_in = res_in; ofree_in = free_in;
         end else pend_in = 1'b1;
      end
      rd_addr = pos_in;

      if (csr_wr_en) begin
         span_in = span_w;
         free_in = clu_type'(span_w - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; span_ff <= CfgW'(NumClusters); free_ff <= FreeMax;
         pos_ff <= '0; pend_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; span_ff <= span_in; free_ff <= free_in;
         pos_ff <= pos_in; pend_ff <= pend_in; ov_ff <= ov_in;
      end
      saved_ff <= saved_in; first_ff <= first_in; prev_ff <= prev_in; got_ff <= got_in;
      amt_ff <= amt_in; cnt_ff <= cnt_in; steps_ff <= steps_in; st_ff <= st_in;
      res_ff <= res_in; ost_ff <= ost_in; ores_ff <= ores_in; ofree_ff <= ofree_in;
   end
endmodule

### bench/tb.sv
// Self-checking bench for cluster_chain_allocator_top: directed and random requests,
// scored against an in-bench model of the cluster table. Depends on cca_pkg.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cca_pkg::*;

   localparam int CycleLimit = 20000000;

   typedef struct packed {
      logic [1:0] status;
      clu_type    cluster;
      clu_type    free_left;
   } table_rsp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_cmd = CMD_ALLOC;
   clu_type          req_cluster_no = '0;
   clu_type          req_amount = '0;
   clu_type          req_link_target = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [1:0]       rsp_status;
   clu_type          rsp_result_cluster;
   clu_type          rsp_free_left;
   logic             csr_wr_en = 1'b0;
   logic [CfgW-1:0]  csr_clusters_in_use = '0;

   bit               used_map [0:NumClusters-1];
   clu_type          link_map [0:NumClusters-1];
   int unsigned      free_cnt;
   int unsigned      vol;
   table_rsp_type    pending_rsp [$];
   clu_type          chain_heads [$];
   int unsigned      mismatches = 0;
   int unsigned      cycles = 0;
   bit               steady = 1'b0;

   cluster_chain_allocator_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_cluster_no(req_cluster_no), .req_amount(req_amount),
      .req_link_target(req_link_target),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_result_cluster(rsp_result_cluster), .rsp_free_left(rsp_free_left),
      .csr_wr_en(csr_wr_en), .csr_clusters_in_use(csr_clusters_in_use)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response side: random back-pressure and scoring
   always @(posedge clock) begin
      table_rsp_type exp_rsp;
      rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 20);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            mismatches = mismatches + 1;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_status);
               mismatches = mismatches + 1;
            end
            if (rsp_result_cluster !== exp_rsp.cluster) begin
               $error("result_cluster: expected %0d, got %0d", exp_rsp.cluster,
                      rsp_result_cluster);
               mismatches = mismatches + 1;
            end
            if (rsp_free_left !== exp_rsp.free_left) begin
               $error("free_left: expected %0d, got %0d", exp_rsp.free_left,
                      rsp_free_left);
               mismatches = mismatches + 1;
            end
         end
      end
   end

   function automatic void table_reset();
      for (int i = 0; i < NumClusters; i++) begin
         used_map[i] = 1'b0;
         link_map[i] = '0;
      end
      used_map[0] = 1'b1;
      vol = NumClusters;
      free_cnt = vol - 1;
   endfunction

   function automatic void volume_set(logic [CfgW-1:0] value);
      vol = (value < 2) ? 2 : (value > NumClusters) ? NumClusters : int'(value);
      free_cnt = vol - 1;
   endfunction

   function automatic table_rsp_type table_apply(logic [1:0] cmd, clu_type cno,
                                                 clu_type amt, clu_type tgt);
      table_rsp_type r;
      int unsigned   saved, first, prev, got, pos, p, q, steps;
      r = '0;
      r.status = ST_OK;
      case (cmd)
         CMD_ALLOC: begin
            if (amt != 0) begin
               saved = free_cnt;
               first = 0; prev = 0; got = 0; pos = 1;
               while (got < amt && pos < vol) begin
                  if (!used_map[pos]) begin
                     used_map[pos] = 1'b1;
                     if (free_cnt > 0) free_cnt--;
                     if (got == 0) first = pos;
                     else link_map[prev] = clu_type'(pos);
                     prev = pos;
                     got++;
                  end
                  pos++;
               end
               if (got == amt) begin
                  link_map[prev] = '0;
                  r.cluster = clu_type'(first);
               end else begin
                  p = first;
                  for (int k = 0; k < got; k++) begin
                     used_map[p] = 1'b0;
                     if (k + 1 < got) p = 32'(link_map[p]);
                  end
                  free_cnt = saved;
                  r.status = ST_NOSPC;
               end
            end
         end
         CMD_FREE: begin
            if (cno >= vol) begin
               r.status = ST_RANGE;
            end else begin
               p = 32'(cno);
               steps = 0;
               forever begin
                  used_map[p] = 1'b0;
                  if (free_cnt < FreeMax) free_cnt++;
                  steps++;
                  q = 32'(link_map[p]);
                  if (q == 0) break;
                  if (q >= vol) begin
                     r.status = ST_RANGE;
                     break;
                  end
                  if (steps >= vol) begin
                     r.status = ST_BROKEN;
                     break;
                  end
                  p = q;
               end
            end
         end
         CMD_WALK: begin
            p = 32'(cno);
            q = 0;
            for (int i = 0; i <= amt; i++) begin
               if (p == 0) begin
                  r.status = ST_BROKEN;
                  break;
               end
               if (p >= vol) begin
                  r.status = ST_RANGE;
                  break;
               end
               q = p;
               p = 32'(link_map[q]);
            end
            if (r.status == ST_OK) r.cluster = clu_type'(q);
         end
         default: begin
            if (cno >= vol) r.status = ST_RANGE;
            else link_map[cno] = tgt;
         end
      endcase
      r.free_left = clu_type'(free_cnt);
      return r;
   endfunction

   task automatic send_request(logic [1:0] cmd, clu_type cno, clu_type amt, clu_type tgt);
      table_rsp_type r;
      while (!steady && $urandom_range(0, 99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_cluster_no <= cno;
      req_amount <= amt;
      req_link_target <= tgt;
      do @(posedge clock); while (!req_ready);
      r = table_apply(cmd, cno, amt, tgt);
      if (cmd == CMD_ALLOC && r.status == ST_OK && amt != 0) chain_heads.push_back(r.cluster);
      pending_rsp.push_back(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_volume(logic [CfgW-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_clusters_in_use <= value;
      @(posedge clock);
      volume_set(value);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_full_volume();
      write_volume(13'd4096);
      send_request(CMD_ALLOC, 12'd0, 12'd0, 12'd0);
      send_request(CMD_ALLOC, 12'd0, 12'd1, 12'd0);
      send_request(CMD_ALLOC, 12'd0, 12'd3, 12'd0);
      send_request(CMD_WALK, 12'd2, 12'd2, 12'd0);
      send_request(CMD_WALK, 12'd2, 12'd3, 12'd0);
      send_request(CMD_WALK, 12'd0, 12'd0, 12'd0);
      send_request(CMD_LINK, 12'd4095, 12'd0, 12'd0);
      send_request(CMD_FREE, 12'd1, 12'd0, 12'd0);
      send_request(CMD_FREE, 12'd1, 12'd0, 12'd0);
   endtask

   task automatic test_small_volume();
      write_volume(13'd16);
      send_request(CMD_ALLOC, 12'd0, 12'd4095, 12'd4095);
      send_request(CMD_ALLOC, 12'd0, 12'd5, 12'd0);
      send_request(CMD_LINK, 12'd4095, 12'd0, 12'd4095);
      send_request(CMD_FREE, 12'd4095, 12'd0, 12'd0);
      send_request(CMD_WALK, 12'd20, 12'd0, 12'd0);
      send_request(CMD_LINK, 12'd6, 12'd0, 12'd4000);
      send_request(CMD_WALK, 12'd2, 12'd4095, 12'd0);
      send_request(CMD_FREE, 12'd2, 12'd0, 12'd0);
      send_request(CMD_ALLOC, 12'd0, 12'd2, 12'd0);
      send_request(CMD_LINK, 12'd3, 12'd0, 12'd2);
      send_request(CMD_WALK, 12'd2, 12'd40, 12'd0);
      send_request(CMD_FREE, 12'd2, 12'd0, 12'd0);
      send_request(CMD_LINK, 12'd0, 12'd0, 12'd0);
      send_request(CMD_FREE, 12'd0, 12'd0, 12'd0);
   endtask

   task automatic test_volume_extremes();
      write_volume(13'd0);
      send_request(CMD_ALLOC, 12'd0, 12'd1, 12'd0);
      send_request(CMD_ALLOC, 12'd0, 12'd2, 12'd0);
      write_volume(13'd1);
      send_request(CMD_WALK, 12'd1, 12'd0, 12'd0);
      write_volume(13'd2);
      send_request(CMD_FREE, 12'd1, 12'd0, 12'd0);
      write_volume(13'd8191);
      send_request(CMD_FREE, 12'd4095, 12'd0, 12'd0);
      send_request(CMD_ALLOC, 12'd0, 12'd4095, 12'd0);
   endtask

   function automatic clu_type pick_cluster();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60 && chain_heads.size() != 0)
         return chain_heads[$urandom_range(0, chain_heads.size() - 1)];
      if (roll < 90) return clu_type'($urandom_range(0, vol - 1));
      return clu_type'($urandom_range(0, 4095));
   endfunction

   task automatic test_random_traffic();
      logic [CfgW-1:0] sizes [6] = '{13'd16, 13'd64, 13'd2, 13'd4096, 13'd300, 13'd8191};
      logic [1:0]      cmd;
      clu_type         amt, tgt;
      int unsigned     roll;
      foreach (sizes[s]) begin
         write_volume(sizes[s]);
         chain_heads.delete();
         steady = (s == 1);
         repeat (18) begin
            roll = $urandom_range(0, 99);
            cmd = (roll < 35) ? CMD_ALLOC : (roll < 55) ? CMD_FREE :
                  (roll < 85) ? CMD_WALK : CMD_LINK;
            amt = ($urandom_range(0, 99) < 88) ? clu_type'($urandom_range(0, 6))
                                               : clu_type'($urandom_range(0, 4095));
            roll = $urandom_range(0, 99);
            tgt = (roll < 10) ? 12'd0 : (roll < 80) ? pick_cluster()
                                                    : clu_type'($urandom_range(0, 4095));
            send_request(cmd, pick_cluster(), amt, tgt);
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      table_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_full_volume();
      test_small_volume();
      test_volume_extremes();
      test_random_traffic();
      drain();
      repeat (20) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d responses never arrived", pending_rsp.size());
         mismatches = mismatches + 1;
      end
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

### files.f
design/cca_pkg.sv
design/cluster_chain_allocator_top.sv
bench/tb.sv
